### rtl/block_average_mosaic_assert.svh
// Assertion macros for the block average mosaic
`ifndef BLOCK_AVERAGE_MOSAIC_ASSERT_SVH
`define BLOCK_AVERAGE_MOSAIC_ASSERT_SVH

// Same-cycle implication, off during reset
`define BAM_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("bam assertion failed");

// Next-cycle implication, off during reset
`define BAM_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bam assertion failed");

`endif

### rtl/bam_pkg.sv
package bam_pkg;

    localparam int NUM_LANES  = 3;
    localparam int COL_W      = 6;
    localparam int ROW_W      = 10;
    localparam int POS_W      = 10;
    localparam int DIM_W      = 11;
    localparam int BS_W       = 5;
    localparam int CH_W       = 8;
    localparam int SUM_W      = 16;
    localparam int CNT_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(100);
    localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(100);
    localparam logic [BS_W-1:0]  BSIZE_RST  = BS_W'(10);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REGION_WIDTH  = 2'd0,
        CFG_REGION_HEIGHT = 2'd1,
        CFG_BLOCK_SIZE    = 2'd2
    } t_cfg_idx;

    typedef logic [NUM_LANES-1:0][CH_W-1:0]  t_rgb_pix;
    typedef logic [NUM_LANES-1:0][SUM_W-1:0] t_rgb_sum;

    typedef struct packed {
        logic             restart;
        logic             emit;
        logic             done;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [BS_W-1:0]  bw;
        logic [BS_W-1:0]  bh;
    } t_pos_info;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             done;
    } t_meta;

    typedef struct packed {
        logic start;
        logic take;
    } t_lane_ctl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_lane_sts;

endpackage

### rtl/bam_pix_if.sv
interface bam_pix_if;
    import bam_pkg::*;

    logic            valid;
    logic            ready;
    logic            start_of_region;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (
        output valid, start_of_region, red, green, blue,
        input  ready
    );

    modport sink (
        input  valid, start_of_region, red, green, blue,
        output ready
    );
endinterface

### rtl/bam_res_if.sv
interface bam_res_if;
    import bam_pkg::*;

    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  avg_red;
    logic [CH_W-1:0]  avg_green;
    logic [CH_W-1:0]  avg_blue;
    logic [COL_W-1:0] block_col;
    logic [ROW_W-1:0] block_row;
    logic             region_done;

    modport source (
        output valid, avg_red, avg_green, avg_blue, block_col, block_row, region_done,
        input  ready
    );

    modport sink (
        input  valid, avg_red, avg_green, avg_blue, block_col, block_row, region_done,
        output ready
    );
endinterface

### rtl/bam_lane.sv
module bam_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bam_pkg::t_lane_ctl          i_ctl,
    input  logic [bam_pkg::SUM_W-1:0]   i_dividend,
    input  logic [bam_pkg::CNT_W-1:0]   i_divisor,
    output bam_pkg::t_lane_sts          o_sts,
    output logic [bam_pkg::CH_W-1:0]    o_quot
);
    import bam_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    typedef enum logic [2:0] {
        LN_IDLE = 3'b001,
        LN_BUSY = 3'b010,
        LN_DONE = 3'b100
    } t_lane_state;

    t_lane_state       r_state, n_state;
    logic [STEP_W-1:0] r_step,  n_step;
    logic [SUM_W-1:0]  r_quo,   n_quo;
    logic [CNT_W-1:0]  r_rem,   n_rem;
    logic [CNT_W-1:0]  r_den,   n_den;
    logic [CNT_W:0]    trial;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_den   = r_den;
        trial   = {r_rem, r_quo[SUM_W-1]};
        unique case (r_state)
            LN_IDLE: begin
                if (i_ctl.start) begin
                    n_quo   = i_dividend;
                    n_rem   = '0;
                    n_den   = i_divisor;
                    n_step  = STEP_W'(SUM_W - 1);
                    n_state = LN_BUSY;
                end
            end
            LN_BUSY: begin
                if (trial >= {1'b0, r_den}) begin
                    n_rem = CNT_W'(trial - {1'b0, r_den});
                    n_quo = {r_quo[SUM_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[CNT_W-1:0];
                    n_quo = {r_quo[SUM_W-2:0], 1'b0};
                end
                n_step = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = LN_DONE;
                end
            end
            LN_DONE: begin
                if (i_ctl.take) begin
                    n_state = LN_IDLE;
                end
            end
            default: begin
                n_state = LN_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LN_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_den  <= n_den;
    end

    assign o_sts.idle = (r_state == LN_IDLE);
    assign o_sts.done = (r_state == LN_DONE);
    assign o_quot     = (|r_quo[SUM_W-1:CH_W]) ? {CH_W{1'b1}} : r_quo[CH_W-1:0];
endmodule

### rtl/bam_merge.sv
module bam_merge (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_start,
    input  bam_pkg::t_meta                           i_meta,
    input  bam_pkg::t_lane_sts [bam_pkg::NUM_LANES-1:0] i_sts,
    input  bam_pkg::t_rgb_pix                        i_quot,
    output bam_pkg::t_lane_ctl                       o_ctl,
    bam_res_if.source                                o_res
);
    import bam_pkg::*;

    logic     all_done;
    logic     take;
    logic     r_vld;
    t_meta    r_meta;
    t_meta    r_out_meta;
    t_rgb_pix r_avg;

    always_comb begin
        all_done = 1'b1;
        for (int l = 0; l < NUM_LANES; l++) begin
            all_done = all_done & i_sts[l].done;
        end
        take = all_done && (!r_vld || o_res.ready);
    end

    assign o_ctl.start = i_start;
    assign o_ctl.take  = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (take) begin
            r_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_meta <= i_meta;
        end
        if (take) begin
            r_avg      <= i_quot;
            r_out_meta <= r_meta;
        end
    end

    assign o_res.valid       = r_vld;
    assign o_res.avg_red     = r_avg[0];
    assign o_res.avg_green   = r_avg[1];
    assign o_res.avg_blue    = r_avg[2];
    assign o_res.block_col   = r_out_meta.col;
    assign o_res.block_row   = r_out_meta.row;
    assign o_res.region_done = r_out_meta.done;
endmodule

### rtl/bam_pos.sv
module bam_pos (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr,
    input  logic [bam_pkg::DIM_W-1:0]  i_width,
    input  logic [bam_pkg::DIM_W-1:0]  i_height,
    input  logic [bam_pkg::BS_W-1:0]   i_bsize,
    input  logic                       i_accept,
    input  logic                       i_sor,
    output logic                       o_run,
    output bam_pkg::t_pos_info         o_info
);
    import bam_pkg::*;

    localparam int OFS_W       = $clog2(1 << (BS_W - 1));
    localparam int MAX_SIDE    = 1 << (BS_W - 1);
    localparam int MAX_DIM     = 1 << POS_W;
    localparam int RECIP_SHIFT = POS_W + BS_W - 1;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    typedef enum logic [2:0] {
        ST_RUN = 3'b001,
        ST_DIV = 3'b010,
        ST_FIX = 3'b100
    } t_pos_state;

    function automatic logic [RECIP_W-1:0] recip_of(input logic [BS_W-1:0] b);
        logic [RECIP_W-1:0] r;
        unique case (b)
            5'd1:    r = 15'd16384;
            5'd2:    r = 15'd8192;
            5'd3:    r = 15'd5462;
            5'd4:    r = 15'd4096;
            5'd5:    r = 15'd3277;
            5'd6:    r = 15'd2731;
            5'd7:    r = 15'd2341;
            5'd8:    r = 15'd2048;
            5'd9:    r = 15'd1821;
            5'd10:   r = 15'd1639;
            5'd11:   r = 15'd1490;
            5'd12:   r = 15'd1366;
            5'd13:   r = 15'd1261;
            5'd14:   r = 15'd1171;
            5'd15:   r = 15'd1093;
            5'd16:   r = 15'd1024;
            default: r = '0;
        endcase
        return r;
    endfunction

    t_pos_state        r_state, n_state;
    logic [POS_W-1:0]  r_x,   n_x;
    logic [POS_W-1:0]  r_y,   n_y;
    logic [OFS_W-1:0]  r_xin, n_xin;
    logic [OFS_W-1:0]  r_yin, n_yin;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [POS_W-1:0]  r_qx,  n_qx;
    logic [POS_W-1:0]  r_qy,  n_qy;

    logic [BS_W-1:0]          b_eff;
    logic [BS_W-1:0]          b_m1;
    logic [DIM_W-1:0]         w_lim;
    logic [DIM_W-1:0]         w_eff;
    logic [DIM_W-1:0]         h_eff;
    logic                     restart;
    logic                     last_x;
    logic                     last_y;
    logic [POS_W-1:0]         x0;
    logic [POS_W-1:0]         y0;
    logic [OFS_W-1:0]         xin0;
    logic [OFS_W-1:0]         yin0;
    logic [COL_W-1:0]         col0;
    logic [ROW_W-1:0]         row0;
    logic [DIM_W-1:0]         span_x;
    logic [DIM_W-1:0]         span_y;
    logic [POS_W+RECIP_W-1:0] prod_x;
    logic [POS_W+RECIP_W-1:0] prod_y;
    logic [POS_W+BS_W-1:0]    back_x;
    logic [POS_W+BS_W-1:0]    back_y;
    logic [POS_W-1:0]         rem_x;
    logic [POS_W-1:0]         rem_y;

    always_comb begin
        b_eff = i_bsize;
        if (i_bsize == '0) begin
            b_eff = BS_W'(1);
        end else if (i_bsize > BS_W'(MAX_SIDE)) begin
            b_eff = BS_W'(MAX_SIDE);
        end
        b_m1  = b_eff - 1'b1;
        w_lim = DIM_W'(b_eff) << COL_W;

        w_eff = (i_width == '0) ? DIM_W'(1) : i_width;
        if (w_eff > w_lim) begin
            w_eff = w_lim;
        end
        if (w_eff > DIM_W'(MAX_DIM)) begin
            w_eff = DIM_W'(MAX_DIM);
        end
        h_eff = (i_height == '0) ? DIM_W'(1) : i_height;
        if (h_eff > DIM_W'(MAX_DIM)) begin
            h_eff = DIM_W'(MAX_DIM);
        end

        restart = i_sor || ({1'b0, r_x} >= w_eff) || ({1'b0, r_y} >= h_eff);
        x0   = restart ? '0 : r_x;
        y0   = restart ? '0 : r_y;
        xin0 = restart ? '0 : r_xin;
        yin0 = restart ? '0 : r_yin;
        col0 = restart ? '0 : r_col;
        row0 = restart ? '0 : r_row;

        last_x = ({1'b0, x0} == DIM_W'(w_eff - 1'b1));
        last_y = ({1'b0, y0} == DIM_W'(h_eff - 1'b1));

        span_x = w_eff - DIM_W'(x0) + DIM_W'(xin0);
        span_y = h_eff - DIM_W'(y0) + DIM_W'(yin0);

        o_info.restart = restart;
        o_info.emit    = (last_x || ({1'b0, xin0} == b_m1))
                      && (last_y || ({1'b0, yin0} == b_m1));
        o_info.done    = last_x && last_y;
        o_info.col     = col0;
        o_info.row     = row0;
        o_info.bw      = (span_x > DIM_W'(b_eff)) ? b_eff : span_x[BS_W-1:0];
        o_info.bh      = (span_y > DIM_W'(b_eff)) ? b_eff : span_y[BS_W-1:0];

        prod_x = r_x * recip_of(b_eff);
        prod_y = r_y * recip_of(b_eff);
        back_x = r_qx * b_eff;
        back_y = r_qy * b_eff;
        rem_x  = r_x - back_x[POS_W-1:0];
        rem_y  = r_y - back_y[POS_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_xin   = r_xin;
        n_yin   = r_yin;
        n_col   = r_col;
        n_row   = r_row;
        n_qx    = r_qx;
        n_qy    = r_qy;
        unique case (r_state)
            ST_RUN: begin
                if (i_accept) begin
                    if (last_x) begin
                        n_x   = '0;
                        n_xin = '0;
                        n_col = '0;
                        if (last_y) begin
                            n_y   = '0;
                            n_yin = '0;
                            n_row = '0;
                        end else begin
                            n_y = y0 + 1'b1;
                            if ({1'b0, yin0} == b_m1) begin
                                n_yin = '0;
                                n_row = row0 + 1'b1;
                            end else begin
                                n_yin = yin0 + 1'b1;
                                n_row = row0;
                            end
                        end
                    end else begin
                        n_x   = x0 + 1'b1;
                        n_y   = y0;
                        n_yin = yin0;
                        n_row = row0;
                        if ({1'b0, xin0} == b_m1) begin
                            n_xin = '0;
                            n_col = col0 + 1'b1;
                        end else begin
                            n_xin = xin0 + 1'b1;
                            n_col = col0;
                        end
                    end
                end
            end
            ST_DIV: begin
                n_qx    = prod_x[RECIP_SHIFT +: POS_W];
                n_qy    = prod_y[RECIP_SHIFT +: POS_W];
                n_state = ST_FIX;
            end
            ST_FIX: begin
                n_xin   = rem_x[OFS_W-1:0];
                n_yin   = rem_y[OFS_W-1:0];
                n_col   = r_qx[COL_W-1:0];
                n_row   = r_qy[ROW_W-1:0];
                n_state = ST_RUN;
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
        if (i_cfg_wr) begin
            n_state = ST_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_x     <= '0;
            r_y     <= '0;
            r_xin   <= '0;
            r_yin   <= '0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_x     <= n_x;
            r_y     <= n_y;
            r_xin   <= n_xin;
            r_yin   <= n_yin;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_qx <= n_qx;
        r_qy <= n_qy;
    end

    assign o_run = (r_state == ST_RUN);
endmodule

### rtl/block_average_mosaic.sv
// A block's last beat passes the beat register, divider lanes and output register in turn.
// Throughput: one pixel beat per cycle unless stalled; block ends go through three 16-step
// divider lanes, so a block end waits until the lanes are idle again, pixels beyond it too.
// A configuration write holds off pixel beats while block offsets are rebuilt.
// Reset is synchronous active low: position, sums (via valid bits) and outputs clear at once.
`include "block_average_mosaic_assert.svh"

module block_average_mosaic (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bam_pix_if.sink                        i_pix,
    bam_res_if.source                      o_res,
    input  logic                           i_cfg_wr_en,
    input  logic [bam_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bam_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import bam_pkg::*;

    localparam int DEPTH = 1 << COL_W;

    logic [DIM_W-1:0] r_cfg_w;
    logic [DIM_W-1:0] r_cfg_h;
    logic [BS_W-1:0]  r_cfg_b;

    logic      run;
    t_pos_info pos;
    logic      ready;
    logic      accept;
    logic      fwd;

    t_rgb_sum         r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    t_rgb_sum         r_rd;

    logic             r_b_vld;
    logic             r_b_zero;
    logic             r_b_fwd;
    logic             r_b_emit;
    logic             r_b_done;
    logic [COL_W-1:0] r_b_col;
    logic [ROW_W-1:0] r_b_row;
    logic [BS_W-1:0]  r_b_bw;
    logic [BS_W-1:0]  r_b_bh;
    t_rgb_pix         r_b_pix;
    t_rgb_sum         r_b_fwd_val;

    t_rgb_sum         base;
    t_rgb_sum         b_sum;
    t_rgb_sum         wdata;
    logic [2*BS_W-1:0] area;
    logic [CNT_W-1:0] count;
    logic             b_go;
    logic             lane_start;
    logic             lanes_free;
    t_meta            meta;

    t_lane_ctl                      lane_ctl;
    t_lane_sts [NUM_LANES-1:0]      lane_sts;
    t_rgb_pix                       lane_quot;
    logic [NUM_LANES-1:0]           lane_idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= WIDTH_RST;
            r_cfg_h <= HEIGHT_RST;
            r_cfg_b <= BSIZE_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_REGION_WIDTH:  r_cfg_w <= i_cfg_wdata[DIM_W-1:0];
                CFG_REGION_HEIGHT: r_cfg_h <= i_cfg_wdata[DIM_W-1:0];
                CFG_BLOCK_SIZE:    r_cfg_b <= i_cfg_wdata[BS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    bam_pos u_pos (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_wr (i_cfg_wr_en),
        .i_width  (r_cfg_w),
        .i_height (r_cfg_h),
        .i_bsize  (r_cfg_b),
        .i_accept (accept),
        .i_sor    (i_pix.start_of_region),
        .o_run    (run),
        .o_info   (pos)
    );

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            base[l]  = r_b_fwd ? r_b_fwd_val[l] : (r_b_zero ? '0 : r_rd[l]);
            b_sum[l] = base[l] + SUM_W'(r_b_pix[l]);
            wdata[l] = r_b_emit ? '0 : b_sum[l];
        end
        area       = r_b_bw * r_b_bh;
        count      = area[CNT_W-1:0];
        lanes_free = &lane_idle;
        b_go       = r_b_vld && (!r_b_emit || lanes_free);
        lane_start = b_go && r_b_emit;
        ready      = run && (!r_b_vld || b_go);
        accept     = i_pix.valid && ready;
        fwd        = r_b_vld && (pos.col == r_b_col);
        meta.col   = r_b_col;
        meta.row   = r_b_row;
        meta.done  = r_b_done;
    end

    assign i_pix.ready = ready;

    always_ff @(posedge i_clk) begin
        if (b_go) begin
            r_mem[r_b_col] <= wdata;
        end
        if (accept) begin
            r_rd <= r_mem[pos.col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (accept && pos.restart) begin
                r_valid <= '0;
            end else if (b_go) begin
                r_valid[r_b_col] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (accept) begin
            r_b_vld <= 1'b1;
        end else if (b_go) begin
            r_b_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_zero    <= pos.restart || (!fwd && !r_valid[pos.col]);
            r_b_fwd     <= !pos.restart && fwd;
            r_b_fwd_val <= wdata;
            r_b_emit    <= pos.emit;
            r_b_done    <= pos.done;
            r_b_col     <= pos.col;
            r_b_row     <= pos.row;
            r_b_bw      <= pos.bw;
            r_b_bh      <= pos.bh;
            r_b_pix     <= {i_pix.blue, i_pix.green, i_pix.red};
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        bam_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (lane_ctl),
            .i_dividend (b_sum[g]),
            .i_divisor  (count),
            .o_sts      (lane_sts[g]),
            .o_quot     (lane_quot[g])
        );
        assign lane_idle[g] = lane_sts[g].idle;
    end

    bam_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lane_start),
        .i_meta  (meta),
        .i_sts   (lane_sts),
        .i_quot  (lane_quot),
        .o_ctl   (lane_ctl),
        .o_res   (o_res)
    );

    `BAM_ASSERT_NXT(a_cfg_holds_pix, i_clk, i_rst_n, i_cfg_wr_en, !ready)
    `BAM_ASSERT_NOW(a_emit_stall, i_clk, i_rst_n, r_b_vld && r_b_emit && !lanes_free, !ready)
    `BAM_ASSERT_NOW(a_lanes_lockstep, i_clk, i_rst_n, 1'b1,
        (lane_idle == '0) || (lane_idle == '1))
endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import bam_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_BEATS  = 1430;
    localparam int PAUSE_SEG     = 7;

    typedef struct packed {
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             done;
    } t_block_avg;

    typedef enum logic {STEP_CFG, STEP_PIX} t_step_kind;

    typedef struct {
        t_step_kind            kind;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  sor;
        t_rgb_pix              pix;
        bit                    typed;
        t_block_avg            blk;
    } t_plan_step;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    t_cfg_idx              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    bam_pix_if pix ();
    bam_res_if res ();

    block_average_mosaic uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix),
        .o_res       (res),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // predictor state
    logic [DIM_W-1:0] cfg_w;
    logic [DIM_W-1:0] cfg_h;
    logic [BS_W-1:0]  cfg_bs;
    t_rgb_sum         band_sum [64];
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;

    t_block_avg blk_expect_q [$];
    t_block_avg due_blk;
    t_plan_step plan [$];

    int err_count;
    int cycle_count;
    int beats_sent;
    int blocks_seen;
    int regions_seen;
    int settings_done;
    int send_idle;
    int recv_idle;

    always #5 i_clk = ~i_clk;

    function automatic void clamp_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                       input logic [BS_W-1:0] bs,
                                       output int ew, output int eh, output int eb);
        eb = (bs == 0) ? 1 : (bs > 16) ? 16 : int'(bs);
        ew = (w == 0) ? 1 : int'(w);
        if (ew > eb * 64) ew = eb * 64;
        if (ew > 1024) ew = 1024;
        eh = (h == 0) ? 1 : int'(h);
        if (eh > 1024) eh = 1024;
    endfunction

    task automatic predict_pixel(input logic sor, input t_rgb_pix p,
                                 output bit emits, output t_block_avg blk);
        int ew, eh, eb, col, row, bw, bh, cnt, q, i, k;
        bit lx, ly;
        int avg [3];
        clamp_dims(cfg_w, cfg_h, cfg_bs, ew, eh, eb);
        emits = 0;
        blk = '0;
        if (sor || pos_x >= ew || pos_y >= eh) begin
            pos_x = '0;
            pos_y = '0;
            for (i = 0; i < 64; i++) band_sum[i] = '0;
        end
        col = pos_x / eb;
        row = pos_y / eb;
        if (col > 63) col = 63;
        for (k = 0; k < 3; k++) band_sum[col][k] = band_sum[col][k] + SUM_W'(p[k]);
        lx = (pos_x == ew - 1);
        ly = (pos_y == eh - 1);
        if ((lx || (pos_x % eb == eb - 1)) && (ly || (pos_y % eb == eb - 1))) begin
            bw = ew - col * eb;
            if (bw > eb) bw = eb;
            bh = eh - row * eb;
            if (bh > eb) bh = eb;
            cnt = bw * bh;
            if (cnt == 0) cnt = 1;
            for (k = 0; k < 3; k++) begin
                q = band_sum[col][k] / cnt;
                avg[k] = (q > 255) ? 255 : q;
            end
            blk.red   = CH_W'(avg[0]);
            blk.green = CH_W'(avg[1]);
            blk.blue  = CH_W'(avg[2]);
            blk.col   = COL_W'(col);
            blk.row   = ROW_W'(row);
            blk.done  = lx && ly;
            band_sum[col] = '0;
            emits = 1;
        end
        if (lx) begin
            pos_x = '0;
            pos_y = ly ? '0 : pos_y + 1'b1;
        end else begin
            pos_x = pos_x + 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on block %0d, %s: got %0d, want %0d", blocks_seen, what, got, want);
        err_count++;
    endtask

    task automatic send_pixel(input logic sor, input t_rgb_pix p,
                              input bit typed, input t_block_avg typed_blk);
        bit emits;
        t_block_avg blk;
        if (beats_sent < 490) begin
            send_idle = 38;
            recv_idle = 69;
        end else if (beats_sent < 980) begin
            send_idle = 69;
            recv_idle = 38;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
        while ($urandom_range(0, 99) < send_idle) begin
            pix.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix.valid           <= 1'b1;
        pix.start_of_region <= sor;
        pix.red             <= p[0];
        pix.green           <= p[1];
        pix.blue            <= p[2];
        do @(posedge i_clk); while (!pix.ready);
        predict_pixel(sor, p, emits, blk);
        if (typed) blk_expect_q.push_back(typed_blk);
        else if (emits) blk_expect_q.push_back(blk);
        beats_sent++;
        @(negedge i_clk);
    endtask

    // hold pixels until every block is out and the lanes have emptied
    task automatic settle_block();
        pix.valid <= 1'b0;
        while (blk_expect_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        unique case (idx)
            CFG_REGION_WIDTH:  cfg_w = data;
            CFG_REGION_HEIGHT: cfg_h = data;
            CFG_BLOCK_SIZE:    cfg_bs = data[BS_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic t_plan_step cfg_step(input t_cfg_idx idx, input int data);
        t_plan_step s;
        s.kind  = STEP_CFG;
        s.idx   = idx;
        s.data  = CFG_DATA_W'(data);
        s.sor   = 1'b0;
        s.pix   = '0;
        s.typed = 0;
        s.blk   = '0;
        return s;
    endfunction

    function automatic t_plan_step pix_step(input logic sor, input int r, input int g,
                                            input int b);
        t_plan_step s;
        s = cfg_step(CFG_REGION_WIDTH, 0);
        s.kind   = STEP_PIX;
        s.sor    = sor;
        s.pix[0] = CH_W'(r);
        s.pix[1] = CH_W'(g);
        s.pix[2] = CH_W'(b);
        return s;
    endfunction

    // one-pixel blocks: the average is the pixel itself
    function automatic t_plan_step pix_step_blk(input logic sor, input int r, input int g,
                                                input int b, input int col, input int row,
                                                input logic done);
        t_plan_step s;
        s = pix_step(sor, r, g, b);
        s.typed     = 1;
        s.blk.red   = CH_W'(r);
        s.blk.green = CH_W'(g);
        s.blk.blue  = CH_W'(b);
        s.blk.col   = COL_W'(col);
        s.blk.row   = ROW_W'(row);
        s.blk.done  = done;
        return s;
    endfunction

    task automatic pick_setting(input int seg, output logic [DIM_W-1:0] w,
                                output logic [DIM_W-1:0] h, output logic [BS_W-1:0] b,
                                output int count);
        int r;
        count = 0;
        unique case (seg)
            0: begin w = 2047; h = 1;    b = 2;  end
            1: begin w = 1;    h = 2047; b = 1;  count = 60; end
            2: begin w = 16;   h = 16;   b = 16; end
            3: begin w = 5;    h = 3;    b = 31; end
            4: begin w = 1024; h = 2;    b = 0;  end
            5: begin w = 1024; h = 1024; b = 16; count = 40; end
            default: begin
                r = $urandom_range(0, 9);
                if (r == 0) b = $urandom_range(0, 1) ? '0 : BS_W'($urandom_range(17, 31));
                else if (r <= 5) b = BS_W'($urandom_range(1, 4));
                else b = BS_W'($urandom_range(1, 16));
                r = $urandom_range(0, 19);
                if (r == 0) w = '0;
                else if (r == 1) w = DIM_W'($urandom_range(1025, 2047));
                else w = DIM_W'($urandom_range(1, 24));
                h = ($urandom_range(0, 19) == 0) ? '0 : DIM_W'($urandom_range(1, 20));
            end
        endcase
    endtask

    always @(negedge i_clk) begin
        res.ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) begin
            if (blk_expect_q.size() == 0) begin
                report_mismatch("unexpected block at col", res.block_col, -1);
            end else begin
                due_blk = blk_expect_q.pop_front();
                if (res.avg_red !== due_blk.red)
                    report_mismatch("avg_red", res.avg_red, due_blk.red);
                if (res.avg_green !== due_blk.green)
                    report_mismatch("avg_green", res.avg_green, due_blk.green);
                if (res.avg_blue !== due_blk.blue)
                    report_mismatch("avg_blue", res.avg_blue, due_blk.blue);
                if (res.block_col !== due_blk.col)
                    report_mismatch("block_col", res.block_col, due_blk.col);
                if (res.block_row !== due_blk.row)
                    report_mismatch("block_row", res.block_row, due_blk.row);
                if (res.region_done !== due_blk.done)
                    report_mismatch("region_done", res.region_done, due_blk.done);
            end
            blocks_seen++;
            if (res.region_done === 1'b1) regions_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d blocks pending", cycle_count,
                     blk_expect_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [BS_W-1:0]  b;
        int count, seg, ew, eh, eb, area, i, rpos, mode, rand_start, left;
        logic sor;
        t_rgb_pix p;
        t_step_kind last_kind;

        i_rst_n             = 1'b0;
        i_cfg_wr_en         = 1'b0;
        i_cfg_idx           = CFG_REGION_WIDTH;
        i_cfg_wdata         = '0;
        pix.valid           = 1'b0;
        pix.start_of_region = 1'b0;
        pix.red             = '0;
        pix.green           = '0;
        pix.blue            = '0;
        res.ready           = 1'b0;
        send_idle           = 38;
        recv_idle           = 69;
        cfg_w               = WIDTH_RST;
        cfg_h               = HEIGHT_RST;
        cfg_bs              = BSIZE_RST;
        pos_x               = '0;
        pos_y               = '0;
        for (i = 0; i < 64; i++) band_sum[i] = '0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings, then one-pixel blocks on a 3x2 region
        plan.push_back(pix_step(1, 255, 255, 255));
        plan.push_back(pix_step(0, 0, 0, 0));
        plan.push_back(cfg_step(CFG_BLOCK_SIZE, 0));
        plan.push_back(cfg_step(CFG_REGION_WIDTH, 3));
        plan.push_back(cfg_step(CFG_REGION_HEIGHT, 2));
        plan.push_back(pix_step_blk(1, 255, 255, 255, 0, 0, 0));
        plan.push_back(pix_step_blk(0, 0, 0, 0, 1, 0, 0));
        plan.push_back(pix_step_blk(0, 1, 2, 3, 2, 0, 0));
        plan.push_back(pix_step_blk(0, 170, 85, 240, 0, 1, 0));
        plan.push_back(pix_step_blk(0, 128, 127, 1, 1, 1, 0));
        plan.push_back(pix_step_blk(0, 15, 240, 60, 2, 1, 1));
        plan.push_back(pix_step_blk(0, 99, 0, 255, 0, 0, 0));
        // oversized block, zero width and height; position now outside the region
        plan.push_back(cfg_step(CFG_BLOCK_SIZE, 31));
        plan.push_back(cfg_step(CFG_REGION_WIDTH, 0));
        plan.push_back(cfg_step(CFG_REGION_HEIGHT, 0));
        plan.push_back(pix_step_blk(0, 200, 100, 50, 0, 0, 1));
        plan.push_back(pix_step_blk(0, 7, 8, 9, 0, 0, 1));
        // 2x2 blocks on 3x3, clipped at right and bottom, restart mid-region
        plan.push_back(cfg_step(CFG_BLOCK_SIZE, 2));
        plan.push_back(cfg_step(CFG_REGION_WIDTH, 3));
        plan.push_back(cfg_step(CFG_REGION_HEIGHT, 3));
        plan.push_back(pix_step(1, 255, 0, 255));
        plan.push_back(pix_step(0, 255, 0, 255));
        plan.push_back(pix_step(0, 3, 200, 17));
        plan.push_back(pix_step(1, 10, 20, 30));
        plan.push_back(pix_step(0, 11, 21, 31));
        plan.push_back(pix_step(0, 255, 255, 255));
        plan.push_back(pix_step(0, 12, 22, 32));
        plan.push_back(pix_step(0, 13, 23, 33));
        plan.push_back(pix_step(0, 0, 128, 64));
        plan.push_back(pix_step(0, 100, 50, 25));
        plan.push_back(pix_step(0, 201, 202, 203));
        plan.push_back(pix_step(0, 254, 1, 127));

        last_kind = STEP_PIX;
        foreach (plan[n]) begin
            if (plan[n].kind == STEP_CFG) begin
                if (last_kind != STEP_CFG) begin
                    settle_block();
                    settings_done++;
                end
                cfg_write(plan[n].idx, plan[n].data);
            end else begin
                send_pixel(plan[n].sor, plan[n].pix, plan[n].typed, plan[n].blk);
            end
            last_kind = plan[n].kind;
        end

        rand_start = beats_sent;
        seg = 0;
        while (beats_sent - rand_start < RANDOM_BEATS) begin
            pick_setting(seg, w, h, b, count);
            settle_block();
            cfg_write(CFG_BLOCK_SIZE, CFG_DATA_W'(b));
            cfg_write(CFG_REGION_WIDTH, w);
            cfg_write(CFG_REGION_HEIGHT, h);
            settings_done++;
            clamp_dims(w, h, b, ew, eh, eb);
            area = ew * eh;
            if (count == 0) begin
                count = area * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0) count += $urandom_range(1, area);
                if (count > 300) count = 300;
            end
            left = RANDOM_BEATS - (beats_sent - rand_start);
            if (count > left) count = left;
            mode = 0;
            for (i = 0; i < count; i++) begin
                rpos = i % area;
                if (rpos == 0) mode = $urandom_range(0, 5);
                sor = (rpos == 0) && ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 49) == 0) sor = 1'b1;
                unique case (mode)
                    0: p = {3{8'hFF}};
                    1: p = '0;
                    2: begin
                        p[0] = CH_W'(255 - $urandom_range(0, 3));
                        p[1] = CH_W'(255 - $urandom_range(0, 3));
                        p[2] = CH_W'(255 - $urandom_range(0, 3));
                    end
                    default: p = t_rgb_pix'($urandom);
                endcase
                if (seg == PAUSE_SEG && i == count / 2) settle_block();
                send_pixel(sor, p, 0, '0);
            end
            seg++;
        end

        settle_block();
        $display("mosaic run: %0d pixel beats, %0d block averages, %0d region ends",
                 beats_sent, blocks_seen, regions_seen);
        $display("%0d region settings, zero, oversized and saturated sizes included",
                 settings_done);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
